/* rtl/core/seven_segment_hex_scan_serializer_macros.svh */
// assertion macros for the seven-segment scan serializer
`ifndef SEVEN_SEGMENT_HEX_SCAN_SERIALIZER_MACROS_SVH
`define SEVEN_SEGMENT_HEX_SCAN_SERIALIZER_MACROS_SVH

`ifndef SYNTHESIS
`define SSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssd check failed");
`define SSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssd check failed");
`else
`define SSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SSD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/ssd_pkg.sv */
// shared types, constants and glyph tables for the scan serializer
package ssd_pkg;

    localparam int DIGIT_COUNT  = 4;
    localparam int SEGMENT_BITS = 8;
    localparam int SCAN_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CNT_W        = $clog2(SEGMENT_BITS);
    localparam int EN_W         = 4;

    localparam logic REQ_REFRESH = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    localparam logic KIND_ERROR   = 1'b0;
    localparam logic KIND_CORRECT = 1'b1;

    localparam logic [1:0] MODE_DASH = 2'd0;
    localparam logic [1:0] MODE_HEX  = 2'd1;

    localparam logic [4:0] CODE_EIGHT = 5'd8;
    localparam logic [4:0] CODE_DASH  = 5'd10;

    typedef struct packed {
        logic                    blank;
        logic [SEGMENT_BITS-1:0] seg;
        logic [EN_W-1:0]         en;
    } job_t;

    function automatic logic [7:0] glyph(input logic [4:0] code);
        logic [7:0] g;
        unique case (code)
            5'd0:    g = 8'hC0;
            5'd1:    g = 8'hF9;
            5'd2:    g = 8'hA4;
            5'd3:    g = 8'hB0;
            5'd4:    g = 8'h99;
            5'd5:    g = 8'h92;
            5'd6:    g = 8'h82;
            5'd7:    g = 8'hF8;
            5'd8:    g = 8'h80;
            5'd9:    g = 8'h90;
            5'd10:   g = 8'hBF;
            5'd12:   g = 8'h86;
            5'd13:   g = 8'h88;
            5'd14:   g = 8'h46;
            5'd15:   g = 8'h00;
            5'd16:   g = 8'h8E;
            5'd17:   g = 8'h88;
            5'd18:   g = 8'h83;
            5'd19:   g = 8'hC6;
            default: g = 8'hFF;
        endcase
        return g;
    endfunction

    function automatic logic [4:0] nibble_code(input logic [3:0] nib);
        logic [4:0] c;
        unique case (nib)
            4'hA:    c = 5'd17;
            4'hB:    c = 5'd18;
            4'hC:    c = 5'd19;
            4'hD:    c = CODE_DASH;
            4'hE:    c = 5'd12;
            4'hF:    c = 5'd16;
            default: c = {1'b0, nib};
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/ssd_front.sv */
// front end: takes requests, keeps counts and digit codes, queues scan jobs
module ssd_front
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         req_fire,
    input  logic         req_type,
    input  logic         count_kind,
    input  logic [7:0]   count_value,
    input  logic [1:0]   display_mode,
    output logic         job_push,
    output ssd_pkg::job_t job
);
    import ssd_pkg::*;

    logic              display_enable_reg;
    logic [7:0]        correct_reg;
    logic [7:0]        correct_next;
    logic [7:0]        error_reg;
    logic [7:0]        error_next;
    logic [4:0]        codes_reg [DIGIT_COUNT];
    logic [4:0]        codes_next [DIGIT_COUNT];
    logic [SCAN_W-1:0] scan_reg;
    logic [SCAN_W-1:0] scan_next;
    logic              is_update;

    assign is_update = req_fire && (req_type == REQ_UPDATE);
    assign job_push  = req_fire && (req_type == REQ_REFRESH);

    always_comb
    begin
        correct_next = correct_reg;
        error_next   = error_reg;
        if (is_update)
        begin
            if (count_kind == KIND_CORRECT)
            begin
                correct_next = count_value;
            end
            else
            begin
                error_next = count_value;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            codes_next[i] = codes_reg[i];
            if (is_update && display_mode == MODE_DASH)
            begin
                codes_next[i] = CODE_DASH;
            end
            else if (is_update && display_mode == MODE_HEX)
            begin
                if (i == 0)
                begin
                    codes_next[i] = nibble_code(correct_next[3:0]);
                end
                else if (i == 1)
                begin
                    codes_next[i] = nibble_code(correct_next[7:4]);
                end
                else if (i == 2)
                begin
                    codes_next[i] = nibble_code(error_next[3:0]);
                end
                else if (i == 3)
                begin
                    codes_next[i] = nibble_code(error_next[7:4]);
                end
            end
        end
    end

    // scan job for the current digit
    always_comb
    begin
        job.blank = !display_enable_reg;
        job.seg   = glyph(codes_reg[scan_reg]);
        if (int'(scan_reg) < EN_W)
        begin
            job.en = EN_W'(1) << scan_reg;
        end
        else
        begin
            job.en = '0;
        end
    end

    always_comb
    begin
        scan_next = scan_reg;
        if (job_push)
        begin
            if (!display_enable_reg || scan_reg == SCAN_W'(DIGIT_COUNT - 1))
            begin
                scan_next = '0;
            end
            else
            begin
                scan_next = scan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg <= 1'b1;
            correct_reg        <= '0;
            error_reg          <= '0;
            scan_reg           <= '0;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                codes_reg[i] <= CODE_EIGHT;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                display_enable_reg <= cfg_wr_data;
            end
            correct_reg <= correct_next;
            error_reg   <= error_next;
            scan_reg    <= scan_next;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                codes_reg[i] <= codes_next[i];
            end
        end
    end

endmodule

/* rtl/core/ssd_queue.sv */
// two-entry job queue between front and back end
module ssd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ssd_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output ssd_pkg::job_t head
);
    import ssd_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/ssd_back.sv */
// back end: serializes one segment byte per enabled job into the output register, one blank beat per blank job
module ssd_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  ssd_pkg::job_t job,
    output logic          job_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,
    output logic          m_axis_tlast
);
    import ssd_pkg::*;

    logic                    busy_reg;
    logic [SEGMENT_BITS-1:0] seg_reg;
    logic [EN_W-1:0]         en_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_data_reg;
    logic                    out_last_reg;
    logic                    out_free;
    logic                    final_bit;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign job_pop   = !busy_reg && job_valid && out_free;
    assign final_bit = (cnt_reg == CNT_W'(SEGMENT_BITS - 1));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // out_data: shift_valid, serial_bit, latch_pulse, digit_enable, pad
    always_ff @(posedge clk)
    begin
        if (busy_reg && out_free)
        begin
            seg_reg      <= seg_reg << 1;
            cnt_reg      <= cnt_reg + 1'b1;
            out_data_reg <= {1'b0, (final_bit ? en_reg : {EN_W{1'b0}}), final_bit,
                             seg_reg[SEGMENT_BITS-1], 1'b1};
            out_last_reg <= final_bit;
        end
        else if (job_pop)
        begin
            seg_reg <= job.seg << 1;
            en_reg  <= job.en;
            cnt_reg <= CNT_W'(1);
            if (job.blank)
            begin
                out_data_reg <= '0;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_data_reg <= {1'b0, {EN_W{1'b0}}, 1'b0, job.seg[SEGMENT_BITS-1], 1'b1};
                out_last_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (busy_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (final_bit)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (job_pop)
            begin
                out_valid_reg <= 1'b1;
                busy_reg      <= !job.blank;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/seven_segment_hex_scan_serializer.sv */
// top level of the seven-segment scan serializer
// Drives a four-digit multiplexed display through a serial-in, latched shift
// register. A count update request is absorbed in the cycle it is taken and
// produces no output. An enabled refresh request produces eight output beats,
// one segment bit each, most significant first and active low; the eighth
// beat carries latch_pulse, the one-hot digit drive and tlast. A refresh
// request while display_enable is 0 produces a single blank beat and restarts
// the scan. The bit serializer emits one beat per cycle unless tready holds it,
// and starts a job only after the last beat of the one before; a two-entry queue
// of refresh jobs lets requests keep arriving while beats wait on tready, until it is full.
`include "seven_segment_hex_scan_serializer_macros.svh"

module seven_segment_hex_scan_serializer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // count_kind, count_value[7:0], display_mode[1:0], pad
    input  logic [0:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // shift_valid, serial_bit, latch_pulse, digit_enable[3:0]
    output logic        m_axis_tlast
);
    import ssd_pkg::*;

    logic       req_fire;
    logic       job_push;
    logic       job_pop;
    logic       q_full;
    logic       q_valid;
    job_t       new_job;
    job_t       head_job;
    logic [3:0] out_drive;

    assign s_axis_tready = !q_full;
    assign req_fire      = s_axis_tvalid && s_axis_tready;
    assign out_drive     = m_axis_tdata[6:3];

    ssd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_fire     (req_fire),
        .req_type     (s_axis_tuser[0]),
        .count_kind   (s_axis_tdata[0]),
        .count_value  (s_axis_tdata[8:1]),
        .display_mode (s_axis_tdata[10:9]),
        .job_push     (job_push),
        .job          (new_job)
    );

    ssd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (new_job),
        .pop       (job_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head_job)
    );

    ssd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (q_valid),
        .job           (head_job),
        .job_pop       (job_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    `SSD_ASSERT_IMP(a_latch_is_last, clk, rst_n, m_axis_tvalid && m_axis_tdata[2], m_axis_tlast)
    `SSD_ASSERT_IMP(a_drive_only_on_latch, clk, rst_n, m_axis_tvalid && !m_axis_tdata[2], out_drive == 4'd0)
    `SSD_ASSERT_IMP(a_drive_onehot, clk, rst_n, m_axis_tvalid, $onehot0(out_drive))
    `SSD_ASSERT_NXT(a_pop_starts_beat, clk, rst_n, job_pop, m_axis_tvalid)

endmodule
